// ===== sv/ffad_pkg.sv =====
// Package: shared types and codes of the first-fit allocator with compaction.
`timescale 1ns / 1ps
package ffad_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_ERASE  = 2'd1,
        OP_DEFRAG = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [1:0] ST_ALLOC   = 2'd0;
    localparam logic [1:0] ST_NULL    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] operand;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] handle;
    } rsp_t;

endpackage

// ===== sv/ffad_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module ffad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/first_fit_allocator_defrag_top.sv =====
// Top level: first-fit allocator with compaction; one RAM holds the table (start, length, handle).
// Each table entry is read, then compared or written. Allocate strobes result_valid with a handle
//   or null (size zero, handles used up, table full or no gap found); erase strobes a result only
//   for an unknown handle, and defragment strobes none. One command at a time: start is taken only
//   while busy is low. Reset (rst_n low, asynchronous) empties the table, sets handle 1.
`timescale 1ns / 1ps
module first_fit_allocator_defrag_top #(
    parameter int MEM_WORDS   = 256,
    parameter int HANDLE_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ffad_pkg::cmd_t cmd,
    output logic           result_valid,
    output ffad_pkg::rsp_t result,
    input  logic           cfg_we,
    input  logic [8:0]     cfg_wdata
);
    import ffad_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam int CW = AW + 1;                 // counts up to MEM_WORDS
    localparam int EW = AW + 1;                 // stored start and length
    localparam int XW = 18;                     // prev_end plus a 16-bit size never overflows
    localparam int RW = EW + EW + HANDLE_BITS;  // packed table row
    localparam logic [HANDLE_BITS:0] HMAX = {1'b0, {HANDLE_BITS{1'b1}}};

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_SREAD  = 8'b00000010,
        S_SCHK   = 8'b00000100,
        S_UREAD  = 8'b00001000,
        S_UWR    = 8'b00010000,
        S_INS    = 8'b00100000,
        S_DREAD  = 8'b01000000,
        S_DWR    = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [8:0] region_reg;
    logic [CW-1:0] live_reg, live_next;
    logic [HANDLE_BITS:0] nh_reg, nh_next;
    logic [CW-1:0] idx_reg, idx_next;   // scan position, insert point, defrag row
    logic [CW-1:0] wk_reg, wk_next;     // shift walker
    logic [XW-1:0] acc_reg, acc_next;   // prev_end or defrag address
    logic [1:0] op_reg, op_next;
    logic [15:0] arg_reg, arg_next;
    logic rv_reg, rv_next;
    rsp_t rsp_reg, rsp_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [RW-1:0] wdata, rdata;
    logic [EW-1:0] r_start, r_len;
    logic [HANDLE_BITS-1:0] r_hdl;
    logic [XW-1:0] region_w, gap_end, fit_end, arg_x;
    logic [CW-1:0] wk_dec;
    logic [HANDLE_BITS+16:0] nh_ext;
    logic hdl_match;

    ffad_ram #(.WIDTH(RW), .DEPTH(MEM_WORDS)) u_tbl (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign {r_start, r_len, r_hdl} = rdata;
    assign busy = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign result = rsp_reg;

    assign arg_x  = {2'b00, arg_reg};
    assign wk_dec = wk_reg - CW'(1);
    assign nh_ext = {16'd0, nh_reg};
    // Handles wider or narrower than the operand compare at full width.
    assign hdl_match = ({16'd0, r_hdl} == {{HANDLE_BITS{1'b0}}, arg_reg});

    // Clamp the region to the memory size.
    always_comb
    begin
        if (XW'(region_reg) > XW'(MEM_WORDS))
            region_w = XW'(MEM_WORDS);
        else
            region_w = XW'(region_reg);
    end

    // Compare unit for allocate: does the gap before the current entry fit the request.
    always_comb
    begin
        if (idx_reg < live_reg && XW'(r_start) < region_w)
            gap_end = XW'(r_start);
        else
            gap_end = region_w;
        fit_end = acc_reg + arg_x;
    end

    always_comb
    begin
        state_next = state_reg;
        live_next = live_reg;
        nh_next = nh_reg;
        idx_next = idx_reg;
        wk_next = wk_reg;
        acc_next = acc_reg;
        op_next = op_reg;
        arg_next = arg_reg;
        rv_next = 1'b0;
        rsp_next = rsp_reg;
        we = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = rdata;
        raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = cmd.op;
                    arg_next = cmd.operand;
                    idx_next = '0;
                    acc_next = '0;
                    case (cmd.op)
                        OP_ALLOC:
                        begin
                            if (cmd.operand == 16'd0 || nh_reg > HMAX
                                || live_reg >= CW'(MEM_WORDS))
                            begin
                                rv_next = 1'b1;
                                rsp_next.status = ST_NULL;
                                rsp_next.handle = 16'd0;
                            end
                            else
                                state_next = S_SREAD;
                        end
                        OP_ERASE:  state_next = S_SREAD;
                        OP_DEFRAG: state_next = S_DREAD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_SREAD: state_next = S_SCHK;   // wait for registered read
            S_SCHK:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (fit_end <= gap_end)
                    begin
                        // Gap found at idx: shift the tail up from the table end.
                        wk_next = live_reg;
                        state_next = (live_reg == idx_reg) ? S_INS : S_UREAD;
                    end
                    else if (idx_reg >= live_reg)
                    begin
                        rv_next = 1'b1;
                        rsp_next.status = ST_NULL;
                        rsp_next.handle = 16'd0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        acc_next = XW'(r_start) + XW'(r_len);
                        idx_next = idx_reg + CW'(1);
                        state_next = S_SREAD;
                    end
                end
                else
                begin
                    if (idx_reg >= live_reg)
                    begin
                        rv_next = 1'b1;
                        rsp_next.status = ST_ILLEGAL;
                        rsp_next.handle = 16'd0;
                        state_next = S_IDLE;
                    end
                    else if (hdl_match)
                    begin
                        // Shift the tail down: walker holds the source row.
                        wk_next = idx_reg + CW'(1);
                        state_next = S_DREAD;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                        state_next = S_SREAD;
                    end
                end
            end
            S_UREAD:
            begin
                raddr = wk_dec[AW-1:0];
                state_next = S_UWR;
            end
            S_UWR:
            begin
                we = 1'b1;
                waddr = wk_reg[AW-1:0];
                wk_next = wk_dec;
                state_next = (wk_dec == idx_reg) ? S_INS : S_UREAD;
            end
            S_INS:
            begin
                we = 1'b1;
                wdata = {acc_reg[EW-1:0], arg_x[EW-1:0], nh_reg[HANDLE_BITS-1:0]};
                waddr = idx_reg[AW-1:0];
                live_next = live_reg + CW'(1);
                nh_next = nh_reg + 1'b1;
                rv_next = 1'b1;
                rsp_next.status = ST_ALLOC;
                rsp_next.handle = nh_ext[15:0];
                state_next = S_IDLE;
            end
            S_DREAD:
            begin
                if (op_reg == OP_ERASE)
                begin
                    if (wk_reg >= live_reg)
                    begin
                        live_next = live_reg - CW'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        raddr = wk_reg[AW-1:0];
                        state_next = S_DWR;
                    end
                end
                else if (idx_reg >= live_reg)
                    state_next = S_IDLE;
                else
                    state_next = S_DWR;
            end
            S_DWR:
            begin
                we = 1'b1;
                if (op_reg == OP_ERASE)
                begin
                    waddr = wk_dec[AW-1:0];
                    wk_next = wk_reg + CW'(1);
                end
                else
                begin
                    wdata = {acc_reg[EW-1:0], r_len, r_hdl};
                    acc_next = acc_reg + XW'(r_len);
                    idx_next = idx_reg + CW'(1);
                end
                state_next = S_DREAD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            region_reg <= 9'd256;
            live_reg   <= '0;
            nh_reg     <= (HANDLE_BITS+1)'(1);
            idx_reg    <= '0;
            wk_reg     <= '0;
            acc_reg    <= '0;
            op_reg     <= OP_NONE;
            arg_reg    <= '0;
            rv_reg     <= 1'b0;
            rsp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                region_reg <= cfg_wdata;
            live_reg <= live_next;
            nh_reg   <= nh_next;
            idx_reg  <= idx_next;
            wk_reg   <= wk_next;
            acc_reg  <= acc_next;
            op_reg   <= op_next;
            arg_reg  <= arg_next;
            rv_reg   <= rv_next;
            rsp_reg  <= rsp_next;
        end
    end

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(MEM_WORDS)) else $error("live count overflow");
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.op == OP_ERASE || cmd.op == OP_DEFRAG)) |=> busy)
        else $error("command not taken");
    a_nh_step: assert property (@(posedge clk) disable iff (!rst_n)
        (nh_reg != $past(nh_reg)) |-> (result_valid && result.status == ST_ALLOC))
        else $error("handle counter moved without allocation");
`endif
endmodule

// ===== verif/tb_first_fit_allocator_defrag_top.sv =====
// Testbench: checks the first-fit allocator against its own table predictor.
`timescale 1ns / 1ps
module tb_first_fit_allocator_defrag_top;
    import ffad_pkg::*;

    localparam int REGION_MAX = 256;
    localparam int HANDLE_LAST = 65535;
    localparam int DRAIN_CYCLES = 4 * REGION_MAX + 16;
    localparam longint CYCLE_LIMIT = 20000000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        result_valid;
    rsp_t        result;
    logic        cfg_we;
    logic [8:0]  cfg_wdata;

    // Predicted table, kept in address order as the block keeps it.
    logic [7:0]  tbl_start [REGION_MAX];
    logic [8:0]  tbl_len [REGION_MAX];
    logic [15:0] tbl_handle [REGION_MAX];
    int          live_blocks;
    logic [16:0] handle_next;
    logic [8:0]  region_reg;

    rsp_t        pending_rsp[$];
    int          error_count;
    longint      cycle_count = 0;

    first_fit_allocator_defrag_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Watchdog: a hung handshake must not run forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Compare every strobed result with the oldest prediction.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && result_valid)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d handle %0d",
                         $time, result.status, result.handle);
                error_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (result.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, result.status);
                    error_count++;
                end
                if (result.handle !== want.handle)
                begin
                    $display("%0t: handle mismatch, expected %0d, actual %0d",
                             $time, want.handle, result.handle);
                    error_count++;
                end
            end
        end
    end

    // Place a block in the lowest gap that fits; the gap never reaches past the region end.
    function automatic rsp_t place_block(int size);
        int   region;
        int   prev_end;
        int   gap_end;
        int   pos;
        bit   found;
        rsp_t r;
        region = (region_reg > REGION_MAX) ? REGION_MAX : int'(region_reg);
        prev_end = 0;
        pos = 0;
        found = 0;
        r.status = ST_NULL;
        r.handle = '0;
        if (size == 0 || handle_next > HANDLE_LAST || live_blocks >= REGION_MAX)
            return r;
        for (int i = 0; i <= live_blocks; i++)
        begin
            gap_end = (i < live_blocks) ? int'(tbl_start[i]) : region;
            if (gap_end > region)
                gap_end = region;
            if (prev_end + size <= gap_end)
            begin
                pos = i;
                found = 1;
                break;
            end
            if (i < live_blocks)
                prev_end = int'(tbl_start[i]) + int'(tbl_len[i]);
        end
        if (!found)
            return r;
        for (int i = live_blocks; i > pos; i--)
        begin
            tbl_start[i] = tbl_start[i - 1];
            tbl_len[i] = tbl_len[i - 1];
            tbl_handle[i] = tbl_handle[i - 1];
        end
        tbl_start[pos] = prev_end[7:0];
        tbl_len[pos] = size[8:0];
        tbl_handle[pos] = handle_next[15:0];
        live_blocks++;
        r.status = ST_ALLOC;
        r.handle = handle_next[15:0];
        handle_next++;
        return r;
    endfunction

    // Drop the block with this handle; returns 0 if the handle is not live.
    function automatic bit free_block(logic [15:0] h);
        for (int i = 0; i < live_blocks; i++)
        begin
            if (tbl_handle[i] == h)
            begin
                for (int j = i; j + 1 < live_blocks; j++)
                begin
                    tbl_start[j] = tbl_start[j + 1];
                    tbl_len[j] = tbl_len[j + 1];
                    tbl_handle[j] = tbl_handle[j + 1];
                end
                live_blocks--;
                return 1;
            end
        end
        return 0;
    endfunction

    // Advance the predicted table by one command and queue what it answers.
    function automatic void predict_cmd(cmd_t c);
        rsp_t r;
        int   addr;
        case (op_t'(c.op))
            OP_ALLOC:
                pending_rsp.push_back(place_block(int'(c.operand)));
            OP_ERASE:
                if (!free_block(c.operand))
                begin
                    r.status = ST_ILLEGAL;
                    r.handle = '0;
                    pending_rsp.push_back(r);
                end
            OP_DEFRAG:
            begin
                addr = 0;
                for (int i = 0; i < live_blocks; i++)
                begin
                    tbl_start[i] = addr[7:0];
                    addr += int'(tbl_len[i]);
                end
            end
            default: ;
        endcase
    endfunction

    // Transfer one command: hold start until the block takes it.
    task automatic send_cmd(op_t op, logic [15:0] operand);
        cmd_t c;
        c.op = op;
        c.operand = operand;
        @(negedge clk);
        cmd = c;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_cmd(c);
        @(negedge clk);
        start = 1'b0;
    endtask

    // Wait until every result is in and the table walk has finished.
    task automatic wait_idle();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        do
            @(posedge clk);
        while (busy);
        repeat (4) @(posedge clk);
    endtask

    // Write region_size; only called with the block idle.
    task automatic write_region(logic [8:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        region_reg = value;
    endtask

    task automatic erase_all_live();
        while (live_blocks > 0)
            send_cmd(OP_ERASE, tbl_handle[$urandom_range(live_blocks - 1)]);
    endtask

    // Extremes of the fields, every op, null cases and unknown handles.
    task automatic test_directed_ops();
        send_cmd(OP_ALLOC, 16'd0);
        send_cmd(OP_ALLOC, 16'd256);
        send_cmd(OP_ALLOC, 16'd1);
        send_cmd(OP_ERASE, 16'd2);
        send_cmd(OP_ERASE, 16'd0);
        send_cmd(OP_ERASE, 16'hFFFF);
        send_cmd(OP_ALLOC, 16'hFFFF);
        send_cmd(OP_ALLOC, 16'd257);
        send_cmd(OP_ALLOC, 16'd100);
        send_cmd(OP_ALLOC, 16'd50);
        send_cmd(OP_ALLOC, 16'd100);
        send_cmd(OP_ERASE, 16'd4);
        send_cmd(OP_ALLOC, 16'd60);
        send_cmd(OP_DEFRAG, 16'hFFFF);
        send_cmd(OP_ALLOC, 16'd56);
        send_cmd(OP_ALLOC, 16'd1);
        send_cmd(OP_NONE, 16'hFFFF);
        send_cmd(OP_NONE, 16'd0);
        send_cmd(OP_ERASE, 16'd3);
        send_cmd(OP_DEFRAG, 16'd0);
        send_cmd(OP_ALLOC, 16'd6);
    endtask

    // Region of zero, above the memory size, and shrunk under live blocks.
    task automatic test_region_settings();
        write_region(9'd0);
        send_cmd(OP_ALLOC, 16'd1);
        write_region(9'd511);
        send_cmd(OP_ALLOC, 16'd1);
        write_region(9'd300);
        send_cmd(OP_ALLOC, 16'd2);
        erase_all_live();
        send_cmd(OP_ALLOC, 16'd40);
        send_cmd(OP_ALLOC, 16'd40);
        send_cmd(OP_ERASE, tbl_handle[0]);
        write_region(9'd50);
        send_cmd(OP_ALLOC, 16'd40);
        send_cmd(OP_ALLOC, 16'd10);
        send_cmd(OP_DEFRAG, 16'd0);
        send_cmd(OP_ALLOC, 16'd10);
        write_region(9'd1);
        send_cmd(OP_ALLOC, 16'd1);
        erase_all_live();
        send_cmd(OP_ALLOC, 16'd1);
        send_cmd(OP_ALLOC, 16'd1);
        erase_all_live();
        write_region(9'd256);
    endtask

    // Fill every table entry, then one more allocate must come back null.
    task automatic test_table_full();
        for (int i = 0; i < REGION_MAX; i++)
            send_cmd(OP_ALLOC, 16'd1);
        send_cmd(OP_ALLOC, 16'd1);
        for (int i = 0; i < 8; i++)
            send_cmd(OP_ERASE, tbl_handle[$urandom_range(live_blocks - 1)]);
        send_cmd(OP_ALLOC, 16'd8);
        send_cmd(OP_DEFRAG, 16'd0);
        send_cmd(OP_ALLOC, 16'd8);
    endtask

    // Mixed traffic, mostly well-formed: live handles, small sizes, some noise.
    task automatic test_random_traffic(int count);
        int          pick;
        logic [15:0] arg;
        op_t         op;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 4)
                write_region(9'd64);
            if (n == count / 2)
                write_region(9'($urandom_range(511)));
            if (n == (count * 3) / 4)
                write_region(9'd256);
            if (n < count - 20 && $urandom_range(4) == 0)
                repeat ($urandom_range(14, 1)) @(posedge clk);
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                op = OP_ALLOC;
                pick = $urandom_range(9);
                if (pick < 8)
                    arg = 16'($urandom_range(16, 1));
                else if (pick == 8)
                    arg = 16'($urandom_range(256));
                else
                    arg = 16'($urandom);
            end
            else if (pick < 80)
            begin
                op = OP_ERASE;
                if (live_blocks > 0 && $urandom_range(4) != 0)
                    arg = tbl_handle[$urandom_range(live_blocks - 1)];
                else
                    arg = 16'($urandom);
            end
            else if (pick < 95)
            begin
                op = OP_DEFRAG;
                arg = 16'($urandom);
            end
            else
            begin
                op = OP_NONE;
                arg = 16'($urandom);
            end
            send_cmd(op, arg);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        live_blocks = 0;
        handle_next = 17'd1;
        region_reg = 9'd256;
        error_count = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_ops();
        test_region_settings();
        test_table_full();
        test_random_traffic(100);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== first_fit_allocator_defrag_top.f =====
sv/ffad_pkg.sv
sv/ffad_ram.sv
sv/first_fit_allocator_defrag_top.sv
verif/tb_first_fit_allocator_defrag_top.sv
